>>> src/fla_pkg.sv
// Shared constants and controller/datapath command and status types for the chunk allocator.
package fla_pkg;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 6;
    localparam int OFS_W   = 22;
    localparam int SIZE_W  = 16;
    localparam int COUNT_W = 7;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_NUM_CHUNKS   = 64;
    localparam int DEF_HEADER_BYTES = 8;

    localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = 1'd1;

    typedef struct packed {
        logic init_start;
        logic init_step;
        logic alloc_read;
        logic alloc_done;
        logic free_do;
        logic result_load;
        logic result_empty;
    } cmd_t;

    typedef struct packed {
        logic head_null;
        logic count_zero;
        logic init_last;
        logic out_free;
    } sts_t;

endpackage

>>> src/fla_req_if.sv
// Request channel: operation and chunk index.
interface fla_req_if;
    logic                      valid;
    logic                      ready;
    logic [fla_pkg::OP_W-1:0]  operation;
    logic [fla_pkg::IDX_W-1:0] chunk_index;

    modport source (output valid, output operation, output chunk_index, input ready);
    modport sink   (input valid, input operation, input chunk_index, output ready);
endinterface

>>> src/fla_rsp_if.sv
// Response channel: status, allocated index and data offset.
interface fla_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      status;
    logic [fla_pkg::IDX_W-1:0] alloc_index;
    logic [fla_pkg::OFS_W-1:0] data_offset;

    modport source (output valid, output status, output alloc_index, output data_offset,
                    input ready);
    modport sink   (input valid, input status, input alloc_index, input data_offset,
                    output ready);
endinterface

>>> src/free_list_chunk_allocator.sv
// Top level of the fixed-size chunk free-list allocator.
//
//   Channel  Dir  Handshake      Payload
//   req      in   valid/ready    operation, chunk_index
//   rsp      out  valid/ready    status, alloc_index, data_offset
//   cfg      in   cfg_we         cfg_index, cfg_wdata
//
// Free, unused opcode, empty allocate and init with zero count load the result as the request is accepted.
// Allocate first reads the link table at the head into a register, then loads the result.
// Init resets the sweep counter, then does one link table write per cycle.
// rsp is a single output register; a new request is taken once it is empty or being taken.
// Reset leaves the head null; the link table is not cleared.
module free_list_chunk_allocator #(
    parameter int NUM_CHUNKS   = fla_pkg::DEF_NUM_CHUNKS,
    parameter int HEADER_BYTES = fla_pkg::DEF_HEADER_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    fla_req_if.sink                       req,
    fla_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [fla_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fla_pkg::CFG_W-1:0]     cfg_wdata
);
    import fla_pkg::*;

    logic [SIZE_W-1:0]  chunk_size_reg;
    logic [SIZE_W-1:0]  chunk_size_next;
    logic [COUNT_W-1:0] chunk_count_reg;
    logic [COUNT_W-1:0] chunk_count_next;
    cmd_t               cmd;
    sts_t               sts;

    always_comb
    begin
        chunk_size_next  = chunk_size_reg;
        chunk_count_next = chunk_count_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHUNK_SIZE:  chunk_size_next  = cfg_wdata[SIZE_W-1:0];
                CFG_CHUNK_COUNT: chunk_count_next = cfg_wdata[COUNT_W-1:0];
                default:         chunk_size_next  = chunk_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_size_reg  <= '0;
            chunk_count_reg <= '0;
        end
        else
        begin
            chunk_size_reg  <= chunk_size_next;
            chunk_count_reg <= chunk_count_next;
        end
    end

    fla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .operation (req.operation),
        .sts       (sts),
        .req_ready (req.ready),
        .cmd       (cmd)
    );

    fla_dp #(
        .NUM_CHUNKS   (NUM_CHUNKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .chunk_index (req.chunk_index),
        .chunk_size  (chunk_size_reg),
        .chunk_count (chunk_count_reg),
        .rsp_ready   (rsp.ready),
        .sts         (sts),
        .rsp_valid   (rsp.valid),
        .status      (rsp.status),
        .alloc_index (rsp.alloc_index),
        .data_offset (rsp.data_offset)
    );
endmodule

>>> src/fla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> src/fla_ctrl.sv
// Allocator controller: sequences init sweep, allocate with a registered link read, free and result load.
module fla_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    input  logic [fla_pkg::OP_W-1:0] operation,
    input  fla_pkg::sts_t            sts,
    output logic                     req_ready,
    output fla_pkg::cmd_t            cmd
);
    import fla_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_INIT  = 2'd1;
    localparam logic [1:0] S_ALLOC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign req_ready = (state_reg == S_IDLE) && sts.out_free;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        OP_INIT:
                        begin
                            cmd.init_start = 1'b1;
                            if (sts.count_zero)
                            begin
                                cmd.result_load = 1'b1;
                            end
                            else
                            begin
                                state_next = S_INIT;
                            end
                        end
                        OP_ALLOC:
                        begin
                            if (sts.head_null)
                            begin
                                cmd.result_load  = 1'b1;
                                cmd.result_empty = 1'b1;
                            end
                            else
                            begin
                                cmd.alloc_read = 1'b1;
                                state_next     = S_ALLOC;
                            end
                        end
                        OP_FREE:
                        begin
                            cmd.free_do     = 1'b1;
                            cmd.result_load = 1'b1;
                        end
                        default:
                        begin
                            cmd.result_load = 1'b1;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (sts.init_last)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_ALLOC:
            begin
                cmd.alloc_done  = 1'b1;
                cmd.result_load = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

>>> src/fla_dp.sv
// Allocator datapath: head pointer, link table, init counter, offset math, result register.
module fla_dp #(
    parameter int NUM_CHUNKS   = fla_pkg::DEF_NUM_CHUNKS,
    parameter int HEADER_BYTES = fla_pkg::DEF_HEADER_BYTES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fla_pkg::cmd_t               cmd,
    input  logic [fla_pkg::IDX_W-1:0]   chunk_index,
    input  logic [fla_pkg::SIZE_W-1:0]  chunk_size,
    input  logic [fla_pkg::COUNT_W-1:0] chunk_count,
    input  logic                        rsp_ready,
    output fla_pkg::sts_t               sts,
    output logic                        rsp_valid,
    output logic                        status,
    output logic [fla_pkg::IDX_W-1:0]   alloc_index,
    output logic [fla_pkg::OFS_W-1:0]   data_offset
);
    import fla_pkg::*;

    localparam int IW = $clog2(NUM_CHUNKS);
    localparam int HW = $clog2(NUM_CHUNKS + 1);
    localparam int STRIDE_W = SIZE_W + 1;
    localparam logic [HW-1:0] NULL_PTR = HW'(NUM_CHUNKS);

    logic [HW-1:0]       head_reg;
    logic [HW-1:0]       head_next;
    logic [IW-1:0]       cnt_reg;
    logic [IW-1:0]       cnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                status_reg;
    logic                status_next;
    logic [IDX_W-1:0]    index_reg;
    logic [IDX_W-1:0]    index_next;
    logic [OFS_W-1:0]    offset_reg;
    logic [OFS_W-1:0]    offset_next;
    logic [OFS_W-1:0]    ofs_calc_reg;
    logic [OFS_W-1:0]    ofs_calc_next;

    logic [31:0]         n32;
    logic [HW-1:0]       n_sat;
    logic [HW-1:0]       cnt_ext;
    logic [HW-1:0]       cnt_plus;
    logic                init_last;
    logic [HW-1:0]       link_val;
    logic [31:0]         idx32;
    logic                free_ok;
    logic [STRIDE_W-1:0] stride;
    logic [31:0]         prod32;
    logic [31:0]         ofs32;
    logic [31:0]         head32;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [HW-1:0]       ram_wdata;
    logic [HW-1:0]       ram_rdata;

    assign n32       = (32'(chunk_count) > NUM_CHUNKS) ? NUM_CHUNKS : 32'(chunk_count);
    assign n_sat     = n32[HW-1:0];
    assign cnt_ext   = HW'(cnt_reg);
    assign cnt_plus  = cnt_ext + HW'(1);
    assign init_last = (cnt_plus == n_sat);
    assign link_val  = init_last ? NULL_PTR : cnt_plus;
    assign idx32     = 32'(chunk_index);
    assign free_ok   = (idx32 < NUM_CHUNKS);
    assign stride    = {1'b0, chunk_size} + STRIDE_W'(HEADER_BYTES);
    assign head32    = 32'(head_reg);
    assign prod32    = head32 * 32'(stride);
    assign ofs32     = prod32 + 32'(HEADER_BYTES);

    assign ram_we    = cmd.init_step || (cmd.free_do && free_ok);
    assign ram_waddr = cmd.init_step ? cnt_reg : idx32[IW-1:0];
    assign ram_wdata = cmd.init_step ? link_val : head_reg;

    fla_ram #(
        .WIDTH (HW),
        .DEPTH (NUM_CHUNKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.alloc_read),
        .raddr (head_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    assign sts.head_null  = (head_reg == NULL_PTR);
    assign sts.count_zero = (n_sat == '0);
    assign sts.init_last  = init_last;
    assign sts.out_free   = !out_valid_reg || rsp_ready;

    always_comb
    begin
        head_next = head_reg;
        priority if (cmd.init_start)
        begin
            head_next = (n_sat == '0) ? NULL_PTR : '0;
        end
        else if (cmd.free_do && free_ok)
        begin
            head_next = idx32[HW-1:0];
        end
        else if (cmd.alloc_done)
        begin
            head_next = ram_rdata;
        end
        else
        begin
            head_next = head_reg;
        end

        cnt_next = cnt_reg;
        if (cmd.init_start)
        begin
            cnt_next = '0;
        end
        else if (cmd.init_step)
        begin
            cnt_next = cnt_reg + IW'(1);
        end

        ofs_calc_next = cmd.alloc_read ? ofs32[OFS_W-1:0] : ofs_calc_reg;

        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        index_next     = index_reg;
        offset_next    = offset_reg;
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
            status_next    = cmd.result_empty;
            index_next     = cmd.alloc_done ? head32[IDX_W-1:0] : '0;
            offset_next    = cmd.alloc_done ? ofs_calc_reg : '0;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= NULL_PTR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        index_reg    <= index_next;
        offset_reg   <= offset_next;
        ofs_calc_reg <= ofs_calc_next;
    end

    assign rsp_valid   = out_valid_reg;
    assign status      = status_reg;
    assign alloc_index = index_reg;
    assign data_offset = offset_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> (!out_valid_reg || rsp_ready))
        else $error("result loaded over a pending response");

    a_alloc_nonnull: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_read |-> (head_reg != NULL_PTR))
        else $error("link read issued at null head");

    a_init_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init_step |-> (cnt_ext < n_sat))
        else $error("init sweep past chunk count");

    a_alloc_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_read |=> cmd.alloc_done)
        else $error("allocate did not complete after link read");
endmodule

>>> test/tb_free_list_chunk_allocator.sv
// Self-checking testbench for the free-list chunk allocator: directed and random bursty requests vs. predictor.
`timescale 1ns / 1ps

module tb_free_list_chunk_allocator;
    import fla_pkg::*;

    localparam int NCH = DEF_NUM_CHUNKS;
    localparam int HDR = DEF_HEADER_BYTES;
    localparam logic [COUNT_W-1:0] NULL_LINK = COUNT_W'(NCH);
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_EMPTY = 1'b1;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
    } alloc_req_t;

    typedef struct {
        logic             status;
        logic [IDX_W-1:0] alloc_index;
        logic [OFS_W-1:0] data_offset;
    } alloc_rsp_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    fla_req_if req_ch ();
    fla_rsp_if rsp_ch ();

    free_list_chunk_allocator #(
        .NUM_CHUNKS   (NCH),
        .HEADER_BYTES (HDR)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic [COUNT_W-1:0] fl_head;
    logic [COUNT_W-1:0] fl_link [NCH];
    logic [SIZE_W-1:0]  cur_size;
    logic [COUNT_W-1:0] cur_count;

    alloc_req_t request_queue [$];
    alloc_rsp_t awaited_rsps [$];
    int         requests_queued;
    int         requests_accepted;
    int         mismatches;
    int         burst_left;
    int         gap_left;
    int         stall_mode;
    int         mode_left;
    int         hold_left;
    int         ready_phase;
    alloc_req_t next_req;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic alloc_rsp_t pool_step(input logic [OP_W-1:0] op,
                                             input logic [IDX_W-1:0] idx);
        alloc_rsp_t  r;
        int unsigned n;
        int unsigned ofs;
        r.status      = ST_OK;
        r.alloc_index = '0;
        r.data_offset = '0;
        case (op)
            OP_INIT:
            begin
                n = (cur_count > NCH) ? NCH : cur_count;
                if (n == 0)
                    fl_head = NULL_LINK;
                else
                begin
                    for (int i = 0; i < n; i++)
                        fl_link[i] = (i + 1 < n) ? COUNT_W'(i + 1) : NULL_LINK;
                    fl_head = '0;
                end
            end
            OP_ALLOC:
            begin
                if (fl_head >= NCH)
                    r.status = ST_EMPTY;
                else
                begin
                    ofs = int'(fl_head) * (int'(cur_size) + HDR) + HDR;
                    r.alloc_index = fl_head[IDX_W-1:0];
                    r.data_offset = ofs[OFS_W-1:0];
                    fl_head = fl_link[fl_head[IDX_W-1:0]];
                end
            end
            OP_FREE:
            begin
                fl_link[idx] = fl_head;
                fl_head = {1'b0, idx};
            end
            default: ;
        endcase
        return r;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.operation   <= OP_INIT;
            req_ch.chunk_index <= '0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                awaited_rsps.push_back(pool_step(req_ch.operation, req_ch.chunk_index));
                requests_accepted++;
            end
            if (!(req_ch.valid && !req_ch.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    next_req = request_queue.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.operation   <= next_req.op;
                    req_ch.chunk_index <= next_req.idx;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // response monitor and ready pattern
    always @(posedge clk or negedge rst_n)
    begin
        logic       rdy;
        alloc_rsp_t exp_rsp;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_mode  = 0;
            mode_left   = 100;
            hold_left   = 0;
            ready_phase = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response: status=%0d index=%0d offset=%0d",
                                 rsp_ch.status, rsp_ch.alloc_index, rsp_ch.data_offset);
                end
                else
                begin
                    exp_rsp = awaited_rsps.pop_front();
                    if (rsp_ch.status !== exp_rsp.status ||
                        rsp_ch.alloc_index !== exp_rsp.alloc_index ||
                        rsp_ch.data_offset !== exp_rsp.data_offset)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp status=%0d index=%0d offset=%0d, got status=%0d index=%0d offset=%0d",
                                     exp_rsp.status, exp_rsp.alloc_index, exp_rsp.data_offset,
                                     rsp_ch.status, rsp_ch.alloc_index, rsp_ch.data_offset);
                    end
                end
            end

            if (mode_left > 0)
                mode_left--;
            else
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(30, 200);
            end
            case (stall_mode)
                0: rdy = 1'b1;
                1: rdy = $urandom_range(0, 1);
                2:
                begin
                    ready_phase = (ready_phase + 1) % 4;
                    rdy = (ready_phase == 0);
                end
                default:
                begin
                    if (hold_left > 0)
                    begin
                        hold_left--;
                        rdy = 1'b0;
                    end
                    else
                    begin
                        rdy = 1'b1;
                        if ($urandom_range(0, 5) == 0)
                            hold_left = $urandom_range(3, 15);
                    end
                end
            endcase
            rsp_ch.ready <= rdy;
        end
    end

    task automatic push_req(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
        alloc_req_t it;
        it.op  = op;
        it.idx = idx;
        request_queue.push_back(it);
        requests_queued++;
    endtask

    task automatic wait_idle();
        while (!(requests_accepted == requests_queued && awaited_rsps.size() == 0))
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= ri;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (ri == CFG_CHUNK_SIZE)
            cur_size = val;
        else
            cur_count = val[COUNT_W-1:0];
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] size, input logic [COUNT_W-1:0] count,
                             input int n_items);
        int r;
        int ce;
        wait_idle();
        write_cfg(CFG_CHUNK_SIZE, size);
        write_cfg(CFG_CHUNK_COUNT, CFG_W'(count));
        ce = (count > NCH) ? NCH : count;
        push_req(OP_INIT, IDX_W'($urandom));
        for (int k = 1; k < n_items; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                push_req(OP_INIT, IDX_W'($urandom));
            else if (r < 50)
                push_req(OP_ALLOC, IDX_W'($urandom));
            else if (r < 92)
            begin
                if (ce > 0 && $urandom_range(0, 3) != 0)
                    push_req(OP_FREE, IDX_W'($urandom_range(0, ce - 1)));
                else
                    push_req(OP_FREE, IDX_W'($urandom));
            end
            else
                push_req(OP_UNUSED, IDX_W'($urandom));
        end
    endtask

    initial begin
        req_ch.valid       = 1'b0;
        req_ch.operation   = OP_INIT;
        req_ch.chunk_index = '0;
        rsp_ch.ready       = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_CHUNK_SIZE;
        cfg_wdata = '0;
        cur_size  = '0;
        cur_count = '0;
        fl_head   = NULL_LINK;
        for (int i = 0; i < NCH; i++)
            fl_link[i] = '0;
        requests_queued   = 0;
        requests_accepted = 0;
        mismatches        = 0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset config: empty pool, zero count init, free/alloc of edge indices
        push_req(OP_ALLOC, 6'd0);
        push_req(OP_INIT, 6'd0);
        push_req(OP_ALLOC, 6'd63);
        push_req(OP_FREE, 6'd63);
        push_req(OP_ALLOC, 6'd0);
        push_req(OP_UNUSED, 6'd5);
        push_req(OP_ALLOC, 6'd0);
        push_req(OP_FREE, 6'd0);
        push_req(OP_FREE, 6'd42);
        push_req(OP_ALLOC, 6'd0);
        push_req(OP_ALLOC, 6'd0);
        push_req(OP_ALLOC, 6'd0);

        // largest size, count above depth saturates
        wait_idle();
        write_cfg(CFG_CHUNK_SIZE, 16'hFFFF);
        write_cfg(CFG_CHUNK_COUNT, CFG_W'(7'h7F));
        push_req(OP_INIT, 6'd0);
        push_req(OP_ALLOC, 6'd0);
        push_req(OP_ALLOC, 6'd0);
        push_req(OP_FREE, 6'd63);
        push_req(OP_ALLOC, 6'd21);
        push_req(OP_UNUSED, 6'd63);
        push_req(OP_INIT, 6'd63);
        push_req(OP_ALLOC, 6'd63);
        push_req(OP_FREE, 6'd63);
        push_req(OP_FREE, 6'd63);
        push_req(OP_ALLOC, 6'd0);
        push_req(OP_ALLOC, 6'd0);

        run_phase(16'd0, 7'd64, 90);
        run_phase(16'hFFFF, 7'd64, 90);
        run_phase(16'd1, 7'd1, 80);
        run_phase(SIZE_W'($urandom), COUNT_W'($urandom_range(0, 64)), 90);
        run_phase(SIZE_W'($urandom), 7'd100, 90);
        run_phase(16'h5A5A, 7'd2, 80);
        run_phase(SIZE_W'($urandom), 7'd0, 40);
        run_phase(SIZE_W'($urandom), COUNT_W'($urandom_range(1, 64)), 90);

        wait_idle();
        repeat (70) @(posedge clk);
        if (awaited_rsps.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
src/fla_pkg.sv
src/fla_req_if.sv
src/fla_rsp_if.sv
src/fla_ram.sv
src/fla_ctrl.sv
src/fla_dp.sv
src/free_list_chunk_allocator.sv
test/tb_free_list_chunk_allocator.sv
